FILE: rtl/core/csma_pkg.sv
// csma_pkg: shared types and codes for the csma retry/backoff queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package csma_pkg;
    localparam logic [1:0] RK_QUEUED   = 2'd0;
    localparam logic [1:0] RK_SCHEDULE = 2'd1;
    localparam logic [1:0] RK_DONE     = 2'd2;
    localparam logic [1:0] RK_DROPPED  = 2'd3;

    localparam logic [2:0] OC_OK       = 3'd0;
    localparam logic [2:0] OC_NOACK    = 3'd1;
    localparam logic [2:0] OC_COLL     = 3'd2;
    localparam logic [2:0] OC_DEFER    = 3'd3;
    localparam logic [2:0] OC_ERROR    = 3'd4;

    localparam logic [2:0] CFG_MIN_BE  = 3'd0;
    localparam logic [2:0] CFG_MAX_BE  = 3'd1;
    localparam logic [2:0] CFG_MAX_BO  = 3'd2;
    localparam logic [2:0] CFG_RETRIES = 3'd3;
    localparam logic [2:0] CFG_PERIOD  = 3'd4;
    localparam logic [2:0] CFG_SEQNO   = 3'd5;

    // result word fields
    typedef struct packed {
        logic        last;
        logic [7:0]  seq_number;
        logic [7:0]  tx_count;
        logic [2:0]  done_status;
        logic [15:0] delay_ticks;
        logic [63:0] dest_addr;
        logic [1:0]  result_kind;
    } result_t;

    // handshake between sequencer and modulo unit
    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [23:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] remainder;
    } mod_rsp_t;
endpackage
`default_nettype wire

FILE: rtl/core/csma_mod_unit.sv
// csma_mod_unit: restoring modulo, one quotient bit per cycle
// depends on csma_pkg
`timescale 1ns / 1ps
`default_nettype none
module csma_mod_unit (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire csma_pkg::mod_req_t  req,
    output csma_pkg::mod_rsp_t       rsp
);
    import csma_pkg::*;

    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [23:0] div_reg, div_next;
    logic        done_reg, done_next;
    logic [24:0] trial;

    // shift next dividend bit in and try a subtract
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        trial     = {8'd0, rem_reg, quo_reg[15]};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            rem_next  = 16'd0;
            quo_next  = req.dividend;
            div_next  = req.divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[14:0], 1'b0};
            if (trial >= {1'b0, div_reg}) rem_next = 16'(trial - {1'b0, div_reg});
            else rem_next = trial[15:0];
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd15) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;
endmodule
`default_nettype wire

FILE: rtl/core/csma_retry_backoff_queue.sv
// csma_retry_backoff_queue: per-neighbor csma transmit bookkeeping
// reset: aresetn synchronous active low; a word with no delay goes idle, lookup,
//   action, output (an ignored outcome skips output); a schedule word also passes the modulo
//   start and wait states, its delay set by the 16-step modulo unit, or zero for a zero
//   backoff range; up to two result words per input, the second earliest in the cycle after
//   the first is taken; one input word at a time, s_tready low until all results leave
`timescale 1ns / 1ps
`default_nettype none
module csma_retry_backoff_queue #(
    parameter int NEIGHBOR_SLOTS       = 4,
    parameter int PACKETS_PER_NEIGHBOR = 4,
    parameter int PACKET_POOL          = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // tdata: neighbor_addr[63:0], tx_limit[71:64], outcome[74:72],
    //   random_value[90:75], zero fill
    input  wire logic [95:0]   s_tdata,
    // tuser: kind
    input  wire logic          s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // tdata: dest_addr[63:0], delay_ticks[79:64], done_status[82:80],
    //   tx_count[90:83], seq_number[98:91], zero fill
    output logic [103:0]       m_tdata,
    // tuser: result_kind
    output logic [1:0]         m_tuser,
    output logic               m_tlast,
    input  wire logic          cfg_we,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [7:0]    cfg_data
);
    import csma_pkg::*;

    localparam int SW = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1;
    localparam int PW = (PACKETS_PER_NEIGHBOR > 1) ? $clog2(PACKETS_PER_NEIGHBOR) : 1;
    localparam int CW = $clog2(PACKETS_PER_NEIGHBOR + 1);
    localparam int TW = CW + 1;
    localparam int UW = $clog2(PACKET_POOL + 1);
    localparam int FD = NEIGHBOR_SLOTS * PACKETS_PER_NEIGHBOR;
    localparam int FW = (FD > 1) ? $clog2(FD) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOOK  = 3'd1;
    localparam logic [2:0] ST_ACT   = 3'd2;
    localparam logic [2:0] ST_MOD   = 3'd3;
    localparam logic [2:0] ST_WAIT  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    // configuration
    logic [3:0] min_be_reg, max_be_reg;
    logic [2:0] max_bo_reg, retries_reg;
    logic [7:0] period_reg, next_seq_reg;

    // slot state
    logic [NEIGHBOR_SLOTS-1:0] slot_valid_reg;
    logic [63:0] slot_addr_reg [NEIGHBOR_SLOTS];
    logic [7:0]  slot_tx_reg   [NEIGHBOR_SLOTS];
    logic [2:0]  slot_coll_reg [NEIGHBOR_SLOTS];
    logic [CW-1:0] slot_count_reg [NEIGHBOR_SLOTS];
    logic [PW-1:0] slot_head_reg  [NEIGHBOR_SLOTS];
    logic [UW-1:0] pool_used_reg;
    logic [7:0]  limit_fifo [FD];
    logic [7:0]  fifo_rd_reg;

    // current word
    logic [2:0]  state_reg;
    logic        kind_reg;
    logic [63:0] addr_reg;
    logic [7:0]  limit_reg;
    logic [2:0]  outc_reg;
    logic [15:0] rnd_reg;
    logic [SW-1:0] s_reg;
    logic        hit_reg, free_reg;
    logic        two_reg;
    result_t     res0_reg, res1_reg;
    logic        sel_reg;
    logic [7:0]  seq_reg;
    logic        fifo_we;
    logic [FW-1:0] fifo_wa;
    logic [FW-1:0] fifo_ra;
    mod_req_t    mreq;
    mod_rsp_t    mrsp;

    csma_mod_unit u_mod (.aclk(aclk), .aresetn(aresetn), .req(mreq), .rsp(mrsp));

    // slot search, small and parallel
    logic [SW-1:0] hit_idx, free_idx;
    logic          hit_any, free_any;
    always_comb begin
        hit_idx = '0; hit_any = 1'b0; free_idx = '0; free_any = 1'b0;
        for (int i = NEIGHBOR_SLOTS - 1; i >= 0; i--) begin
            if (slot_valid_reg[i] && slot_addr_reg[i] == addr_reg) begin
                hit_any = 1'b1; hit_idx = SW'(i);
            end
            if (!slot_valid_reg[i]) begin
                free_any = 1'b1; free_idx = SW'(i);
            end
        end
    end

    // head limit of the matching slot, read during the lookup step
    assign fifo_ra = FW'(hit_idx) * FW'(PACKETS_PER_NEIGHBOR)
                     + FW'(slot_head_reg[hit_idx]);

    // backoff range for slot s with given collision count
    logic [4:0]  be_sum;
    logic [3:0]  be;
    logic [15:0] pow_m1;
    logic [23:0] range;
    logic [2:0]  coll_for_be;
    always_comb begin
        be_sum = 5'(coll_for_be) + 5'(min_be_reg);
        be     = (be_sum > 5'(max_be_reg)) ? max_be_reg : be_sum[3:0];
        pow_m1 = 16'((17'd1 << be) - 17'd1);
        range  = 24'(pow_m1) * 24'(period_reg);
    end

    // derived facts for the action step
    logic [CW-1:0] cnt_s;
    logic [PW-1:0] head_s;
    logic [PW-1:0] head_inc;
    logic [TW-1:0] tail_sum;
    logic [PW-1:0] tail_idx;
    logic [7:0]    tx_inc;
    logic [3:0]    coll_inc;
    always_comb begin
        cnt_s    = slot_count_reg[s_reg];
        head_s   = slot_head_reg[s_reg];
        head_inc = (head_s == PW'(PACKETS_PER_NEIGHBOR - 1)) ? '0 : PW'(head_s + PW'(1));
        tail_sum = TW'(head_s) + TW'(cnt_s);
        if (!hit_reg) tail_idx = '0;
        else if (tail_sum >= TW'(PACKETS_PER_NEIGHBOR))
            tail_idx = PW'(tail_sum - TW'(PACKETS_PER_NEIGHBOR));
        else tail_idx = PW'(tail_sum);
        tx_inc   = slot_tx_reg[s_reg] + 8'd1;
        coll_inc = 4'(slot_coll_reg[s_reg]) + 4'd1;
    end

    logic [7:0] seq_now;
    assign seq_now = (next_seq_reg == 8'd0) ? 8'd1 : next_seq_reg;

    // delay collision count chosen in the action step
    logic [2:0] coll_sel_reg;
    assign coll_for_be = coll_sel_reg;

    logic mod_zero_reg;
    assign mreq.start    = (state_reg == ST_MOD) && (range != 24'd0);
    assign mreq.dividend = rnd_reg;
    assign mreq.divisor  = range;

    assign fifo_wa = FW'(s_reg) * FW'(PACKETS_PER_NEIGHBOR) + FW'(tail_idx);
    assign fifo_we = (state_reg == ST_ACT) && !kind_reg && (hit_reg || free_reg)
                     && !(cnt_s >= CW'(PACKETS_PER_NEIGHBOR) && hit_reg)
                     && !(pool_used_reg >= UW'(PACKET_POOL));

    always_ff @(posedge aclk) begin
        if (fifo_we)
            limit_fifo[fifo_wa] <= (limit_reg == 8'd0) ? 8'(retries_reg) + 8'd1
                                                       : limit_reg;
        fifo_rd_reg <= limit_fifo[fifo_ra];
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            min_be_reg     <= 4'd3;
            max_be_reg     <= 4'd5;
            max_bo_reg     <= 3'd5;
            retries_reg    <= 3'd7;
            period_reg     <= 8'd1;
            next_seq_reg   <= 8'd0;
            slot_valid_reg <= '0;
            pool_used_reg  <= '0;
            for (int i = 0; i < NEIGHBOR_SLOTS; i++) begin
                slot_count_reg[i] <= '0;
                slot_head_reg[i]  <= '0;
            end
            sel_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_MIN_BE:  min_be_reg  <= cfg_data[3:0];
                    CFG_MAX_BE:  max_be_reg  <= cfg_data[3:0];
                    CFG_MAX_BO:  max_bo_reg  <= cfg_data[2:0];
                    CFG_RETRIES: retries_reg <= cfg_data[2:0];
                    CFG_PERIOD:  period_reg  <= cfg_data;
                    CFG_SEQNO:   next_seq_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        kind_reg  <= s_tuser;
                        addr_reg  <= s_tdata[63:0];
                        limit_reg <= s_tdata[71:64];
                        outc_reg  <= s_tdata[74:72];
                        rnd_reg   <= s_tdata[90:75];
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    hit_reg <= hit_any;
                    free_reg <= free_any;
                    s_reg <= hit_any ? hit_idx : free_idx;
                    if (!kind_reg) begin
                        seq_reg      <= seq_now;
                        next_seq_reg <= seq_now + 8'd1;
                    end else seq_reg <= 8'd0;
                    state_reg <= ST_ACT;
                end
                ST_ACT: begin
                    result_t    r0, r1;
                    logic [2:0] nst;
                    logic       ntwo;
                    logic [2:0] csel;
                    logic [7:0] ntx;
                    logic [2:0] ncoll;
                    logic       fin;
                    r0 = '{last: 1'b1, seq_number: seq_reg, tx_count: 8'd0,
                           done_status: 3'd0, delay_ticks: 16'd0,
                           dest_addr: addr_reg, result_kind: RK_QUEUED};
                    r1 = '{last: 1'b1, seq_number: 8'd0, tx_count: 8'd0,
                           done_status: 3'd0, delay_ticks: 16'd0,
                           dest_addr: addr_reg, result_kind: RK_SCHEDULE};
                    nst   = ST_OUT;
                    ntwo  = 1'b0;
                    csel  = coll_sel_reg;
                    ntx   = slot_tx_reg[s_reg];
                    ncoll = slot_coll_reg[s_reg];
                    fin   = 1'b0;
                    if (!kind_reg) begin
                        if (!hit_reg && !free_reg) begin
                            r0.result_kind = RK_DROPPED;
                            r0.done_status = OC_ERROR;
                            r0.tx_count    = 8'd1;
                        end else if ((hit_reg && cnt_s >= CW'(PACKETS_PER_NEIGHBOR))
                                     || pool_used_reg >= UW'(PACKET_POOL)) begin
                            r0.result_kind = RK_DROPPED;
                            r0.done_status = OC_ERROR;
                            r0.tx_count    = 8'd1;
                            if (!hit_reg || cnt_s == '0) slot_valid_reg[s_reg] <= 1'b0;
                        end else begin
                            slot_valid_reg[s_reg] <= 1'b1;
                            pool_used_reg <= pool_used_reg + UW'(1);
                            if (!hit_reg) begin
                                slot_addr_reg[s_reg]  <= addr_reg;
                                slot_tx_reg[s_reg]    <= 8'd0;
                                slot_coll_reg[s_reg]  <= 3'd0;
                                slot_count_reg[s_reg] <= CW'(1);
                                slot_head_reg[s_reg]  <= '0;
                            end else slot_count_reg[s_reg] <= cnt_s + CW'(1);
                            if (!hit_reg || cnt_s == '0) begin
                                r0.result_kind = RK_SCHEDULE;
                                csel = hit_reg ? slot_coll_reg[s_reg] : 3'd0;
                                nst = ST_MOD;
                            end
                        end
                    end else if (!hit_reg || cnt_s == '0 || outc_reg == OC_DEFER) begin
                        nst = ST_IDLE;
                    end else begin
                        // outcome processing on the head packet
                        case (outc_reg)
                            OC_OK: begin
                                ntx = tx_inc; ncoll = 3'd0; fin = 1'b1;
                            end
                            OC_NOACK: begin
                                ntx = tx_inc; ncoll = 3'd0;
                                fin = (tx_inc >= fifo_rd_reg);
                            end
                            OC_COLL: begin
                                if (coll_inc > 4'(max_bo_reg)) begin
                                    ncoll = 3'd0; ntx = tx_inc;
                                end else ncoll = coll_inc[2:0];
                                fin = (ntx >= fifo_rd_reg);
                            end
                            default: fin = 1'b1;
                        endcase
                        if (!fin) begin
                            slot_tx_reg[s_reg]   <= ntx;
                            slot_coll_reg[s_reg] <= ncoll;
                            r0.result_kind = RK_SCHEDULE;
                            r0.seq_number  = 8'd0;
                            csel = ncoll;
                            nst = ST_MOD;
                        end else begin
                            r0.result_kind = RK_DONE;
                            r0.done_status = outc_reg;
                            r0.tx_count    = ntx;
                            slot_head_reg[s_reg] <= head_inc;
                            slot_count_reg[s_reg] <= cnt_s - CW'(1);
                            if (pool_used_reg != '0) pool_used_reg <= pool_used_reg - UW'(1);
                            slot_tx_reg[s_reg]   <= 8'd0;
                            slot_coll_reg[s_reg] <= 3'd0;
                            if (cnt_s > CW'(1)) begin
                                r0.last = 1'b0;
                                ntwo = 1'b1;
                                csel = 3'd0;
                                nst = ST_MOD;
                            end else slot_valid_reg[s_reg] <= 1'b0;
                        end
                    end
                    res0_reg     <= r0;
                    res1_reg     <= r1;
                    two_reg      <= ntwo;
                    sel_reg      <= 1'b0;
                    coll_sel_reg <= csel;
                    state_reg    <= nst;
                end
                ST_MOD: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (mod_zero_reg || mrsp.done) begin
                        if (two_reg) res1_reg.delay_ticks <= mod_zero_reg ? 16'd0
                                                             : mrsp.remainder;
                        else res0_reg.delay_ticks <= mod_zero_reg ? 16'd0
                                                     : mrsp.remainder;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        if (two_reg && !sel_reg) sel_reg <= 1'b1;
                        else state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // zero range check, registered while the modulo unit starts
    always_ff @(posedge aclk) begin
        if (state_reg == ST_ACT) mod_zero_reg <= 1'b0;
        else if (state_reg == ST_MOD) mod_zero_reg <= (range == 24'd0);
    end

    result_t cur;
    assign cur      = sel_reg ? res1_reg : res0_reg;
    assign s_tready = (state_reg == ST_IDLE) && aresetn;
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tuser  = cur.result_kind;
    assign m_tlast  = cur.last;
    assign m_tdata  = {5'd0, cur.seq_number, cur.tx_count, cur.done_status,
                       cur.delay_ticks, cur.dest_addr};

    // pool never exceeds its size
    a_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        pool_used_reg <= UW'(PACKET_POOL)) else $error("pool overflow");
    // no input taken while a result is pending
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("ready during output");
    // modulo result never reaches the range
    a_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT && mrsp.done && !mod_zero_reg)
        |-> (24'(mrsp.remainder) < range)) else $error("bad remainder");
endmodule
`default_nettype wire

FILE: tb/tb_csma_retry_backoff_queue.sv
// tb_csma_retry_backoff_queue: self-checking bench for the csma retry/backoff queue
// depends on csma_pkg and csma_retry_backoff_queue; predicts result words in-bench
`timescale 1ns / 1ps
`default_nettype none
module tb_csma_retry_backoff_queue;
    import csma_pkg::*;

    localparam int NSLOT = 4;
    localparam int QDEPTH = 4;
    localparam int POOL = 8;
    localparam int IDLE_PCT = 35;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] addr;
        logic [15:0] delay;
        logic [2:0]  status;
        logic [7:0]  txc;
        logic [7:0]  seq;
        logic        last;
    } exp_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [95:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic [1:0] m_tuser;
    logic m_tlast;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    csma_retry_backoff_queue DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor copy of registers and state
    logic [3:0]  p_min_be, p_max_be;
    logic [2:0]  p_max_bo, p_retries;
    logic [7:0]  p_period, p_seq;
    logic        sl_valid [NSLOT];
    logic [63:0] sl_addr [NSLOT];
    logic [7:0]  sl_tx [NSLOT];
    logic [2:0]  sl_coll [NSLOT];
    int          sl_count [NSLOT];
    int          sl_head [NSLOT];
    logic [7:0]  limits [NSLOT*QDEPTH];
    int          pool_used;

    exp_word_t expected_words[$];
    int errors = 0;
    int cycles = 0;
    bit no_idle = 1'b0;
    bit rx_hold = 1'b0;
    logic [63:0] addr_set [6];

    function automatic logic [15:0] backoff_ticks(int s, logic [15:0] rnd);
        int be;
        int range;
        be = sl_coll[s] + p_min_be;
        if (be > p_max_be) be = p_max_be;
        range = ((1 << be) - 1) * p_period;
        if (range == 0) return 16'd0;
        return 16'(rnd % range);
    endfunction

    function automatic void push_word(logic [1:0] k, logic [63:0] a, logic [15:0] d,
                                      logic [2:0] st, logic [7:0] t, logic [7:0] sq,
                                      logic l);
        exp_word_t w;
        w.kind = k; w.addr = a; w.delay = d; w.status = st;
        w.txc = t; w.seq = sq; w.last = l;
        expected_words.push_back(w);
    endfunction

    function automatic int lookup_slot(logic [63:0] a);
        for (int i = 0; i < NSLOT; i++)
            if (sl_valid[i] && sl_addr[i] == a) return i;
        return -1;
    endfunction

    function automatic void finish_head(int s, logic [2:0] st, logic [15:0] rnd);
        logic [7:0] ntx;
        ntx = sl_tx[s];
        sl_head[s] = (sl_head[s] + 1) % QDEPTH;
        sl_count[s]--;
        if (pool_used > 0) pool_used--;
        if (sl_count[s] > 0) begin
            sl_tx[s] = 0;
            sl_coll[s] = 0;
            push_word(RK_DONE, sl_addr[s], 0, st, ntx, 0, 1'b0);
            push_word(RK_SCHEDULE, sl_addr[s], backoff_ticks(s, rnd), 0, 0, 0, 1'b1);
        end else begin
            sl_valid[s] = 1'b0;
            push_word(RK_DONE, sl_addr[s], 0, st, ntx, 0, 1'b1);
        end
    endfunction

    // predict the result words caused by one accepted input word
    function automatic void predict_queue(logic kind, logic [63:0] a, logic [7:0] lim,
                                          logic [2:0] oc, logic [15:0] rnd);
        int s;
        bit fresh;
        logic [7:0] sq, hl;
        int c;
        fresh = 1'b0;
        if (kind == 1'b0) begin
            if (p_seq == 0) p_seq = 1;
            sq = p_seq;
            p_seq = p_seq + 8'd1;
            s = lookup_slot(a);
            if (s < 0) begin
                for (int i = 0; i < NSLOT; i++)
                    if (!sl_valid[i]) begin s = i; break; end
                if (s < 0) begin
                    push_word(RK_DROPPED, a, 0, OC_ERROR, 1, sq, 1'b1);
                    return;
                end
                sl_valid[s] = 1'b1; sl_addr[s] = a; sl_tx[s] = 0; sl_coll[s] = 0;
                sl_count[s] = 0; sl_head[s] = 0; fresh = 1'b1;
            end
            if (sl_count[s] >= QDEPTH || pool_used >= POOL) begin
                if (fresh || sl_count[s] == 0) sl_valid[s] = 1'b0;
                push_word(RK_DROPPED, a, 0, OC_ERROR, 1, sq, 1'b1);
                return;
            end
            if (lim == 0) lim = p_retries + 8'd1;
            limits[s*QDEPTH + (sl_head[s] + sl_count[s]) % QDEPTH] = lim;
            sl_count[s]++;
            pool_used++;
            if (sl_count[s] == 1)
                push_word(RK_SCHEDULE, a, backoff_ticks(s, rnd), 0, 0, sq, 1'b1);
            else
                push_word(RK_QUEUED, a, 0, 0, 0, sq, 1'b1);
            return;
        end
        s = lookup_slot(a);
        if (s < 0 || sl_count[s] == 0) return;
        hl = limits[s*QDEPTH + sl_head[s]];
        case (oc)
            OC_OK: begin
                sl_coll[s] = 0;
                sl_tx[s] = sl_tx[s] + 8'd1;
                finish_head(s, OC_OK, rnd);
            end
            OC_NOACK, OC_COLL: begin
                if (oc == OC_NOACK) begin
                    sl_coll[s] = 0;
                    sl_tx[s] = sl_tx[s] + 8'd1;
                end else begin
                    c = sl_coll[s] + 1;
                    if (c > p_max_bo) begin
                        c = 0;
                        sl_tx[s] = sl_tx[s] + 8'd1;
                    end
                    sl_coll[s] = 3'(c);
                end
                if (sl_tx[s] >= hl) finish_head(s, oc, rnd);
                else push_word(RK_SCHEDULE, a, backoff_ticks(s, rnd), 0, 0, 0, 1'b1);
            end
            OC_DEFER: ;
            default: finish_head(s, oc, rnd);
        endcase
    endfunction

    function automatic void predictor_reset();
        p_min_be = 3; p_max_be = 5; p_max_bo = 5; p_retries = 7; p_period = 1; p_seq = 0;
        for (int i = 0; i < NSLOT; i++) begin
            sl_valid[i] = 0; sl_addr[i] = 0; sl_tx[i] = 0; sl_coll[i] = 0;
            sl_count[i] = 0; sl_head[i] = 0;
        end
        for (int i = 0; i < NSLOT*QDEPTH; i++) limits[i] = 0;
        pool_used = 0;
    endfunction

    // cycle limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL csma_retry_backoff_queue");
            $finish;
        end
    end

    // receiver ready: held low while rx_hold, always high with no_idle, else random idling
    always @(posedge aclk) begin
        if (rx_hold) m_tready <= 1'b0;
        else if (no_idle) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(99) >= IDLE_PCT);
    end

    // result word checker
    always @(posedge aclk) begin
        exp_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h", m_tdata);
            end else begin
                w = expected_words.pop_front();
                if (m_tuser !== w.kind || m_tdata[63:0] !== w.addr ||
                    m_tdata[79:64] !== w.delay || m_tdata[82:80] !== w.status ||
                    m_tdata[90:83] !== w.txc || m_tdata[98:91] !== w.seq ||
                    m_tlast !== w.last) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch exp k%0d a%h d%0d st%0d tx%0d sq%0d l%0d",
                            w.kind, w.addr, w.delay, w.status, w.txc, w.seq, w.last);
                        $display("         got k%0d a%h d%0d st%0d tx%0d sq%0d l%0d",
                            m_tuser, m_tdata[63:0], m_tdata[79:64], m_tdata[82:80],
                            m_tdata[90:83], m_tdata[98:91], m_tlast);
                    end
                end
            end
        end
    end

    task automatic send_word(logic kind, logic [63:0] a, logic [7:0] lim,
                             logic [2:0] oc, logic [15:0] rnd);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {5'd0, rnd, oc, lim, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_queue(kind, a, lim, oc, rnd);
        s_tvalid <= 1'b0;
        // the block stays busy after an accept
        @(posedge aclk);
    endtask

    task automatic drain_results();
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        drain_results();
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MIN_BE:  p_min_be = val[3:0];
            CFG_MAX_BE:  p_max_be = val[3:0];
            CFG_MAX_BO:  p_max_bo = val[2:0];
            CFG_RETRIES: p_retries = val[2:0];
            CFG_PERIOD:  p_period = val;
            CFG_SEQNO:   p_seq = val;
            default: ;
        endcase
    endtask

    task automatic set_all(logic [3:0] mn, logic [3:0] mx, logic [2:0] bo,
                           logic [2:0] rt, logic [7:0] per, logic [7:0] sq);
        write_reg(CFG_MIN_BE, mn); write_reg(CFG_MAX_BE, mx); write_reg(CFG_MAX_BO, bo);
        write_reg(CFG_RETRIES, rt); write_reg(CFG_PERIOD, per); write_reg(CFG_SEQNO, sq);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // directed: extremes, every outcome, drops, ignored outcomes, seq wrap
    task automatic test_directed();
        logic [63:0] a0, a1;
        a0 = 64'hFFFF_FFFF_FFFF_FFFF;
        a1 = 64'h0;
        send_word(1'b1, a0, 8'd0, OC_OK, 16'hFFFF);        // unknown neighbor
        send_word(1'b0, a0, 8'd0, OC_OK, 16'hFFFF);
        send_word(1'b0, a0, 8'd255, 3'd7, 16'h0);
        send_word(1'b1, a0, 8'd0, OC_DEFER, 16'h1234);
        send_word(1'b1, a0, 8'd0, OC_COLL, 16'hFFFF);
        send_word(1'b1, a0, 8'd0, OC_NOACK, 16'hABCD);
        send_word(1'b1, a0, 8'd0, OC_OK, 16'h5555);
        send_word(1'b1, a0, 8'd0, 3'd5, 16'h7777);
        for (int i = 0; i < 5; i++) send_word(1'b0, a1, 8'd1, 3'd0, 16'(i * 999));
        for (int i = 0; i < 4; i++) send_word(1'b0, 64'(i + 1), 8'd2, 3'd0, 16'hFFFF);
        send_word(1'b1, a1, 8'd0, 3'd6, 16'h00FF);
        send_word(1'b1, a1, 8'd0, 3'd7, 16'hFF00);
        send_word(1'b1, a1, 8'd0, OC_ERROR, 16'h8001);
        send_word(1'b1, a1, 8'd0, OC_NOACK, 16'h0001);
        send_word(1'b1, a1, 8'd0, OC_NOACK, 16'h0001);
        set_all(4'd0, 4'd3, 3'd0, 3'd0, 8'd255, 8'd255);
        send_word(1'b0, a1, 8'd0, 3'd0, 16'hFFFF);
        send_word(1'b0, a1, 8'd0, 3'd0, 16'hFFFF);
        send_word(1'b1, a1, 8'd0, OC_COLL, 16'hFFFF);
    endtask

    // flush all slots so random phases start well defined
    task automatic flush_slots();
        for (int i = 0; i < NSLOT; i++)
            while (sl_valid[i] && sl_count[i] > 0)
                send_word(1'b1, sl_addr[i], 8'd0, OC_ERROR, 16'($urandom));
    endtask

    // random traffic over a small address set, mostly well formed
    task automatic test_random(int n);
        int r;
        logic [63:0] a;
        for (int i = 0; i < n; i++) begin
            a = ($urandom_range(9) == 0) ? rand64() : addr_set[$urandom_range(5)];
            r = $urandom_range(99);
            if (r < 45)
                send_word(1'b0, a,
                          ($urandom_range(2) == 0) ? 8'($urandom) : 8'($urandom_range(3)),
                          3'($urandom), 16'($urandom));
            else
                send_word(1'b1, a, 8'($urandom),
                          ($urandom_range(4) == 0) ? 3'($urandom) : 3'($urandom_range(3)),
                          16'($urandom));
        end
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        rx_hold = 1'b1;
        fork
            begin
                for (int i = 0; i < 8; i++)
                    send_word(1'b0, addr_set[i % 3], 8'd3, 3'd0, 16'($urandom));
            end
            begin
                repeat (300) @(posedge aclk);
                rx_hold = 1'b0;
            end
        join
        drain_results();
    endtask

    initial begin
        for (int i = 0; i < 6; i++) addr_set[i] = rand64();
        predictor_reset();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        flush_slots();
        set_all(4'd3, 4'd5, 3'd5, 3'd7, 8'd1, 8'd0);
        test_random(150);
        flush_slots();
        set_all(4'd8, 4'd8, 3'd5, 3'd7, 8'd255, 8'd200);
        no_idle = 1'b1;
        test_random(150);
        no_idle = 1'b0;
        flush_slots();
        set_all(4'd0, 4'd3, 3'd0, 3'd0, 8'd1, 8'd254);
        test_random(150);
        flush_slots();
        test_backpressure();
        flush_slots();
        set_all(4'd2, 4'd6, 3'd3, 3'd2, 8'($urandom_range(1, 255)), 8'($urandom));
        test_random(250);
        drain_results();
        if (errors == 0 && expected_words.size() == 0) begin
            $display("PASS csma_retry_backoff_queue");
        end else begin
            $display("FAIL csma_retry_backoff_queue");
        end
        $finish;
    end
endmodule
`default_nettype wire
